FILE: rtl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and constants for the string mismatch percentage block.
// ----------------------------------------------------------------------------
package smp_pkg;

	// Default for the saturation limit of the position counters.
	localparam int MAX_LEN_DEF = 1024;

	// Width of the percentage result, 0..100.
	localparam int Q_W = 7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // an input item is taken this cycle
		logic capture;   // the accepted item is the last one: freeze counters
		logic prep;      // form the dividend and the aligned divisor
		logic step;      // one restoring divide step
		logic out_load;  // write the result into the output register
	} smp_cmd_t;

endpackage

FILE: rtl/smp_ctrl.sv
// ----------------------------------------------------------------------------
// smp_ctrl
// Controller: input and output handshakes and sequencing of the divider.
// ----------------------------------------------------------------------------
module smp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            last,
	input  logic            out_stall,
	output logic            in_stall,
	output logic            out_valid,
	output smp_pkg::smp_cmd_t cmd
);
	import smp_pkg::*;

	localparam int STEP_W = $clog2(Q_W);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.capture  = cmd.accept && last;
		cmd.prep     = (state_q == S_PREP);
		cmd.step     = (state_q == S_DIV);
		cmd.out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture)
					state_d = S_PREP;
			end
			S_PREP: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (step_q == STEP_W'(Q_W - 1))
					state_d = S_DONE;
			end
			S_DONE: begin
				if (cmd.out_load)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.prep)
				step_q <= '0;
			else if (cmd.step)
				step_q <= step_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/smp_dp.sv
// ----------------------------------------------------------------------------
// smp_dp
// Datapath: position counters, radix-2 restoring divider, output register.
// ----------------------------------------------------------------------------
module smp_dp #(
	parameter int MAX_LEN = smp_pkg::MAX_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smp_pkg::smp_cmd_t      cmd,
	input  logic [7:0]             left_char,
	input  logic                   left_present,
	input  logic [7:0]             right_char,
	input  logic                   right_present,
	output logic [smp_pkg::Q_W-1:0] distance,
	output logic                   overflow
);
	import smp_pkg::*;

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	// dividend < len * 128, so it fits in CNT_W + Q_W bits
	localparam int DIV_W = CNT_W + Q_W;

	logic [CNT_W-1:0] mis_q, len_q;
	logic             ovf_q;
	logic [CNT_W-1:0] mis_n, len_n;
	logic             ovf_n;
	logic [CNT_W-1:0] fin_mis_q, fin_len_q;
	logic             fin_ovf_q;
	logic [DIV_W-1:0] rem_q, dsh_q, num;
	logic [Q_W-1:0]   quo_q;
	logic             zero_q;
	logic             ge;
	logic             counted, differs;
	logic [Q_W-1:0]   distance_q;
	logic             overflow_q;

	// per-position judgment and saturating counters
	always_comb begin
		counted = left_present | right_present;
		differs = (left_present != right_present) || (left_char != right_char);
		mis_n   = mis_q;
		len_n   = len_q;
		ovf_n   = ovf_q;
		if (counted) begin
			if (len_q == CNT_W'(MAX_LEN)) begin
				ovf_n = 1'b1;
			end else begin
				len_n = len_q + 1'b1;
				if (differs)
					mis_n = mis_q + 1'b1;
			end
		end
	end

	// mis*100 = mis*64 + mis*32 + mis*4, plus half the length for rounding
	assign num = (DIV_W'(fin_mis_q) << 6) + (DIV_W'(fin_mis_q) << 5)
	           + (DIV_W'(fin_mis_q) << 2) + DIV_W'(fin_len_q >> 1);
	assign ge  = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mis_q <= '0;
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.accept) begin
			if (cmd.capture) begin
				mis_q <= '0;
				len_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				mis_q <= mis_n;
				len_q <= len_n;
				ovf_q <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fin_mis_q <= mis_n;
			fin_len_q <= len_n;
			fin_ovf_q <= ovf_n;
		end
		if (cmd.prep) begin
			rem_q  <= num;
			dsh_q  <= DIV_W'(fin_len_q) << (Q_W - 1);
			zero_q <= (fin_len_q == '0);
		end else if (cmd.step) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
		if (cmd.out_load) begin
			distance_q <= zero_q ? '0 : quo_q;
			overflow_q <= fin_ovf_q;
		end
	end

	assign distance = distance_q;
	assign overflow = overflow_q;

endmodule

FILE: rtl/string_mismatch_percent.sv
// ----------------------------------------------------------------------------
// string_mismatch_percent
// Rounded percentage of mismatching positions between two streamed strings.
// ----------------------------------------------------------------------------
// Each input item is one aligned character pair with a present flag per side.
// A position counts toward the longer length when either side is present and
// is a mismatch when only one side is present or the bytes differ. Items of a
// string are taken one per clock. The item marked last is counted too; then
// the block computes round(mismatch*100/length), 0 for two empty strings, on
// a radix-2 restoring divider that retires one quotient bit per cycle. Input
// is held off after the last item while the dividend is formed, the divider
// steps through the quotient bits and the result is written to the output
// register. The last of these stretches for as long as the previous result
// still waits, stalled, in the output register. The result sits in that
// register until taken, and the next string may already stream in.
// Counters saturate at MAX_LEN counted positions; a counted position beyond
// that sets overflow, and the percentage covers the first MAX_LEN positions.
// ----------------------------------------------------------------------------
module string_mismatch_percent #(
	parameter int MAX_LEN = smp_pkg::MAX_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              left_char,
	input  logic                    left_present,
	input  logic [7:0]              right_char,
	input  logic                    right_present,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [smp_pkg::Q_W-1:0] distance,
	output logic                    overflow
);
	import smp_pkg::*;

	smp_cmd_t cmd;

	// sequencing and both handshakes
	smp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// counters, divider and result register
	smp_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.left_char     (left_char),
		.left_present  (left_present),
		.right_char    (right_char),
		.right_present (right_present),
		.distance      (distance),
		.overflow      (overflow)
	);

endmodule

FILE: rtl/smp_checker.sv
// ----------------------------------------------------------------------------
// smp_checker
// Port-level checks for string_mismatch_percent, bound to the top level.
// ----------------------------------------------------------------------------
module smp_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    last,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [smp_pkg::Q_W-1:0] distance,
	input logic                    overflow
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance) && $stable(overflow))
		else $error("stalled result changed");

	// a percentage never exceeds 100
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance <= 7'd100)
		else $error("distance above 100");

	// the divider runs after a last item, so input is held off
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall)
		else $error("input taken during divide");

	// inside a string the block never stalls the input
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last |=> !in_stall)
		else $error("stall inside a string");

endmodule

bind string_mismatch_percent smp_checker u_smp_checker (.*);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the string mismatch percentage block.
// ----------------------------------------------------------------------------
// Character pairs are streamed into the block over the valid/stall input
// channel. Each accepted pair is also tallied by a local model of the
// counters. The model queues the percentage and the overflow flag it expects
// whenever a pair marked last is taken. A monitor pops one expectation per
// accepted output item and compares both fields. Both sides insert idle
// cycles at random, except during one quiet stretch of the random test.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import smp_pkg::*;

	localparam int MAX_LEN     = MAX_LEN_DEF;
	localparam int CYCLE_LIMIT = 400000;   // slowest legal run stays far below this
	localparam int RAND_ITEMS  = 490;

	// One aligned character pair, as it goes over the input channel
	typedef struct packed {
		logic [7:0] left_char;
		logic       left_present;
		logic [7:0] right_char;
		logic       right_present;
		logic       last;
	} char_pair_t;

	// One percentage item, as it comes back over the output channel
	typedef struct packed {
		logic [Q_W-1:0] distance;
		logic           overflow;
	} pct_result_t;

	logic           clk           = 1'b0;
	logic           arst_n        = 1'b0;
	logic           in_valid      = 1'b0;
	logic           in_stall;
	logic [7:0]     left_char     = 8'h00;
	logic           left_present  = 1'b0;
	logic [7:0]     right_char    = 8'h00;
	logic           right_present = 1'b0;
	logic           last          = 1'b0;
	logic           out_valid;
	logic           out_stall     = 1'b0;
	logic [Q_W-1:0] distance;
	logic           overflow;

	// Local copy of the block's counters
	int unsigned  mism_seen;
	int unsigned  len_seen;
	bit           ovf_seen;

	pct_result_t  pct_expected[$];   // percentages still owed by the block
	int           fail_count;
	int           items_sent;
	bit           calm;              // set: neither side idles

	string_mismatch_percent u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.left_char     (left_char),
		.left_present  (left_present),
		.right_char    (right_char),
		.right_present (right_present),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.distance      (distance),
		.overflow      (overflow)
	);

	always #10 clk = ~clk;

	// Count one accepted pair; on the last pair, queue the percentage and
	// start a fresh comparison.
	function automatic void tally_position(input char_pair_t p);
		pct_result_t r;
		int unsigned pct;
		if (p.left_present || p.right_present) begin
			// saturated: the pair is dropped but remembered as overflow
			if (len_seen >= MAX_LEN) begin
				ovf_seen = 1'b1;
			end else begin
				len_seen++;
				// absent side's byte never matters
				if (p.left_present != p.right_present || p.left_char != p.right_char) begin
					mism_seen++;
				end
			end
		end
		if (p.last) begin
			pct = 0;
			if (len_seen != 0) begin
				pct = (mism_seen * 100 + len_seen / 2) / len_seen;   // round half up
			end
			r.distance = pct[Q_W-1:0];
			r.overflow = ovf_seen;
			pct_expected.push_back(r);
			mism_seen = 0;
			len_seen  = 0;
			ovf_seen  = 1'b0;
		end
	endfunction

	// Offer one pair and hold it until taken. Called at a rising edge; returns
	// at the edge that accepted the pair, with valid still high.
	task automatic send_pair(input char_pair_t p);
		int gap;
		bit taken;
		if (!calm && $urandom_range(99) < 23) begin
			gap = 1;
			while ($urandom_range(99) < 23) gap++;
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		left_char     <= p.left_char;
		left_present  <= p.left_present;
		right_char    <= p.right_char;
		right_present <= p.right_present;
		last          <= p.last;
		taken = 1'b0;
		// stall is settled by the falling edge and holds until the next rise
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		tally_position(p);
		items_sent++;
	endtask

	task automatic send_fields(input logic [7:0] lc, input logic lp,
			input logic [7:0] rc, input logic rp, input logic lst);
		char_pair_t p;
		p = '{left_char: lc, left_present: lp, right_char: rc, right_present: rp,
			last: lst};
		send_pair(p);
	endtask

	// One comparison: len_l and len_r characters, aligned from the start.
	// match_pct sets how often the right byte copies the left one. A noisy
	// string scrambles the present flags, leaving holes and broken tails.
	task automatic send_string(input int len_l, input int len_r,
			input int match_pct, input bit noisy);
		char_pair_t p;
		int n;
		n = (len_l > len_r) ? len_l : len_r;
		if (n == 0) begin
			// two empty strings still take one closing pair
			p.left_char     = 8'($urandom);
			p.right_char    = 8'($urandom);
			p.left_present  = 1'b0;
			p.right_present = 1'b0;
			p.last          = 1'b1;
			send_pair(p);
		end
		for (int i = 0; i < n; i++) begin
			p.left_char     = 8'($urandom);
			p.right_char    = ($urandom_range(99) < match_pct) ? p.left_char : 8'($urandom);
			p.left_present  = noisy ? 1'($urandom) : (i < len_l);
			p.right_present = noisy ? 1'($urandom) : (i < len_r);
			p.last          = (i == n - 1);
			send_pair(p);
		end
	endtask

	// Hold the input side until every owed percentage has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pct_expected.size() != 0) @(posedge clk);
	endtask

	// Corner cases, one short comparison each
	task automatic test_directed_cases();
		send_fields(8'h00, 1'b0, 8'hFF, 1'b0, 1'b1);   // both empty -> 0
		send_fields(8'h00, 1'b1, 8'h00, 1'b1, 1'b0);   // equal extremes -> 0
		send_fields(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1);
		send_fields(8'h00, 1'b1, 8'hFF, 1'b1, 1'b1);   // every bit differs -> 100
		send_fields(8'h41, 1'b1, 8'h41, 1'b0, 1'b0);   // right absent, same byte -> 100
		send_fields(8'h42, 1'b1, 8'h42, 1'b0, 1'b1);
		send_fields(8'h5A, 1'b0, 8'h5A, 1'b1, 1'b1);   // left absent -> 100
		send_fields(8'h11, 1'b1, 8'h11, 1'b1, 1'b0);   // hole in the middle -> 50
		send_fields(8'h22, 1'b0, 8'h33, 1'b0, 1'b0);
		send_fields(8'h44, 1'b1, 8'h45, 1'b1, 1'b1);
		send_fields(8'h61, 1'b1, 8'h61, 1'b1, 1'b0);   // one in three -> 33
		send_fields(8'h62, 1'b1, 8'h62, 1'b1, 1'b0);
		send_fields(8'h63, 1'b1, 8'h00, 1'b0, 1'b1);
		for (int i = 0; i < 8; i++) begin                  // 12.5 rounds up to 13
			send_fields(8'(8'h30 + i), 1'b1, (i == 7) ? 8'h80 : 8'(8'h30 + i), 1'b1,
				i == 7);
		end
		send_fields(8'h7F, 1'b1, 8'h80, 1'b1, 1'b0);   // empty closing pair -> 100
		send_fields(8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
	endtask

	// Longest string: reaches the limit, then runs past it
	task automatic test_saturation();
		send_string(MAX_LEN + 2, MAX_LEN, 50, 1'b0);
	endtask

	// Sender goes quiet after each comparison until its result is out
	task automatic test_pause_until_drained();
		for (int i = 0; i < 4; i++) begin
			send_string($urandom_range(6), $urandom_range(6), 60, 1'b0);
			wait_drained();
		end
	endtask

	// Mostly well-formed strings of random content, some noisy ones
	task automatic test_random_strings();
		int start;
		int done;
		int l_len;
		int r_len;
		bit paused;
		start  = items_sent;
		paused = 1'b0;
		while (items_sent - start < RAND_ITEMS) begin
			done = items_sent - start;
			calm = (done >= 150 && done < 350);   // one quiet stretch
			if ($urandom_range(9) == 0) begin
				l_len = $urandom_range(40);
				r_len = $urandom_range(40);
			end else begin
				l_len = $urandom_range(12);
				r_len = ($urandom_range(2) == 0) ? l_len : $urandom_range(12);
			end
			send_string(l_len, r_len, $urandom_range(100), $urandom_range(99) < 15);
			if (!paused && done >= 400) begin
				wait_drained();
				paused = 1'b1;
			end
		end
		calm = 1'b0;
	endtask

	// Output side stalls at random outside the quiet stretch
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 23);
	end

	// Result monitor: outputs are stable at the falling edge, and an item seen
	// valid and unstalled there is taken at the next rising edge.
	initial begin : result_check
		pct_result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pct_expected.size() == 0) begin
					$display("%0t: unexpected result distance=%0d overflow=%0d",
						$time, distance, overflow);
					fail_count++;
				end else begin
					want = pct_expected.pop_front();
					if (distance !== want.distance) begin
						$display("%0t: distance expected %0d actual %0d",
							$time, want.distance, distance);
						fail_count++;
					end
					if (overflow !== want.overflow) begin
						$display("%0t: overflow expected %0d actual %0d",
							$time, want.overflow, overflow);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		mism_seen  = 0;
		len_seen   = 0;
		ovf_seen   = 1'b0;
		fail_count = 0;
		items_sent = 0;
		calm       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_saturation();
		test_pause_until_drained();
		test_random_strings();

		// drain, then leave room for the divider and the output register
		in_valid <= 1'b0;
		@(posedge clk);
		while (pct_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/smp_pkg.sv
rtl/smp_ctrl.sv
rtl/smp_dp.sv
rtl/string_mismatch_percent.sv
rtl/smp_checker.sv
verif/tb_top.sv
